FILE: sv/earliest_timestamp_multi_queue_arbiter_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the earliest timestamp arbiter
// shared clocked assertion forms with async reset disable
// ----------------------------------------------------------------------------
`ifndef EARLIEST_TIMESTAMP_MULTI_QUEUE_ARBITER_CORE_DEFINES_SVH
`define EARLIEST_TIMESTAMP_MULTI_QUEUE_ARBITER_CORE_DEFINES_SVH

// property that must hold at every edge out of reset
`define ETA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the next cycle
`define ETA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/eta_arb_pkg.sv
// ----------------------------------------------------------------------------
// eta_arb_pkg
// shared types and codes of the earliest timestamp arbiter
// ----------------------------------------------------------------------------
package eta_arb_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned TagW  = 16;
  localparam int unsigned PhW   = 3;

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_SET_TIME = 2'd2,
    ACT_SET_ACT  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_IDLE_WIN  = 3'd2,
    ST_NO_ACTIVE = 3'd3,
    ST_ORDER_ERR = 3'd4
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0] etime;
    logic [TagW-1:0]  tag;
    logic [PhW-1:0]   phase;
  } entry_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       port;
    logic [TagW-1:0]  tag;
    logic [PhW-1:0]   phase;
    logic [TimeW-1:0] otime;
  } result_t;

endpackage

FILE: sv/eta_arb_store.sv
// ----------------------------------------------------------------------------
// eta_arb_store
// entry memory, one synchronous write port and one registered read port
// ----------------------------------------------------------------------------
module eta_arb_store #(
  parameter int unsigned AddrW = 7
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  eta_arb_pkg::entry_t  wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output eta_arb_pkg::entry_t  rdata_o
);

  eta_arb_pkg::entry_t mem [2**AddrW];
  eta_arb_pkg::entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/eta_arb_heads.sv
// ----------------------------------------------------------------------------
// eta_arb_heads
// per-port head time cache and earliest search over active ports
// ----------------------------------------------------------------------------
module eta_arb_heads #(
  parameter int unsigned Ports = 16,
  parameter int unsigned PortW = 4
) (
  input  logic                               clk_i,
  input  logic                               head_we_i,
  input  logic [PortW-1:0]                   head_port_i,
  input  logic [eta_arb_pkg::TimeW-1:0]      head_time_i,
  input  logic [Ports-1:0]                   active_i,
  input  logic [Ports-1:0]                   nonempty_i,
  input  logic [Ports-1:0][eta_arb_pkg::TimeW-1:0] local_time_i,
  output logic                               found_o,
  output logic [PortW-1:0]                   win_o,
  output logic [eta_arb_pkg::TimeW-1:0]      best_o
);

  localparam int unsigned Leaves = 2 ** PortW;

  logic [Ports-1:0][eta_arb_pkg::TimeW-1:0] head_q;
  logic [eta_arb_pkg::TimeW-1:0]            cand [Ports];
  logic                                     node_found [2*Leaves];
  logic [PortW-1:0]                         node_idx   [2*Leaves];
  logic [eta_arb_pkg::TimeW-1:0]            node_time  [2*Leaves];

  // head time of each port, written whenever a head changes
  always_ff @(posedge clk_i) begin
    if (head_we_i) begin
      head_q[head_port_i] <= head_time_i;
    end
  end

  always_comb begin
    for (int i = 0; i < Ports; i++) begin
      cand[i] = nonempty_i[i] ? head_q[i] : local_time_i[i];
    end
  end

  // comparator tree, the lower port keeps ties at every node
  always_comb begin
    node_found[0] = 1'b0;
    node_idx[0]   = '0;
    node_time[0]  = '0;
    for (int k = 0; k < Leaves; k++) begin
      node_found[Leaves+k] = 1'b0;
      node_idx[Leaves+k]   = PortW'(k);
      node_time[Leaves+k]  = '0;
      if (k < Ports) begin
        node_found[Leaves+k] = active_i[k];
        node_time[Leaves+k]  = cand[k];
      end
    end
    for (int n = int'(Leaves) - 1; n >= 1; n--) begin
      if (node_found[2*n+1] &&
          (!node_found[2*n] || node_time[2*n+1] < node_time[2*n])) begin
        node_found[n] = 1'b1;
        node_idx[n]   = node_idx[2*n+1];
        node_time[n]  = node_time[2*n+1];
      end else begin
        node_found[n] = node_found[2*n];
        node_idx[n]   = node_idx[2*n];
        node_time[n]  = node_time[2*n];
      end
    end
  end

  assign found_o = node_found[1];
  assign win_o   = node_idx[1];
  assign best_o  = node_time[1];

endmodule

FILE: sv/earliest_timestamp_multi_queue_arbiter_core.sv
// ----------------------------------------------------------------------------
// earliest_timestamp_multi_queue_arbiter_core
// Each input word is one command; each command gives exactly one result word.
// A push, set time or set active, and a pop that finds no active port or an
// idle winner, register their result word at accept. A pop of a non-empty
// winner holds the input through the read and out states: a comparator tree
// over the mirrored head times picks the winner and its entry is fetched from
// the entry memory (one read port, registered read), then the entry is retired
// and the result word written, then the winner's new head time is refreshed.
// Head times are mirrored in a per-port register so the search needs no memory
// port. One command is in flight at a time; a new command enters once the last
// result word is taken, or in the same cycle. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "earliest_timestamp_multi_queue_arbiter_core_defines.svh"

module earliest_timestamp_multi_queue_arbiter_core #(
  parameter int unsigned PORTS      = 16,
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[1:0], port[5:2], payload_tag[21:6], phase_code[24:22],
  // stamp[72:25], active_flag[73], zero pad to 80
  input  logic [79:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], selected_port[6:3], out_tag[22:7], out_phase[25:23],
  // out_time[73:26], zero pad to 80
  output logic [79:0] m_axis_tdata_o
);

  localparam int unsigned SlotW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PIdxW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned AddrW = PIdxW + SlotW;
  localparam int unsigned TW    = eta_arb_pkg::TimeW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  // input field split
  eta_arb_pkg::action_e     act;
  logic [3:0]               in_port;
  logic [15:0]              in_tag;
  logic [2:0]               in_phase;
  logic [TW-1:0]            in_time;
  logic                     in_flag;
  assign act      = eta_arb_pkg::action_e'(s_axis_tdata_i[1:0]);
  assign in_port  = s_axis_tdata_i[5:2];
  assign in_tag   = s_axis_tdata_i[21:6];
  assign in_phase = s_axis_tdata_i[24:22];
  assign in_time  = s_axis_tdata_i[72:25];
  assign in_flag  = s_axis_tdata_i[73];

  state_e state_q, state_d;
  logic [PORTS-1:0][SlotW-1:0] rd_ptr_q, wr_ptr_q;
  logic [PORTS-1:0][CntW-1:0]  cnt_q;
  logic [PORTS-1:0][TW-1:0]    ltime_q;
  logic [PORTS-1:0]            active_q, nonempty;
  logic [PIdxW-1:0]            win_q;
  logic                        ovalid_q, ovalid_d;
  eta_arb_pkg::result_t        res_q, res_d;

  logic [PIdxW-1:0] pidx;
  logic             port_ok;
  assign port_ok = 32'(in_port) < PORTS;
  assign pidx    = PIdxW'(in_port);

  always_comb begin
    for (int i = 0; i < PORTS; i++) begin
      nonempty[i] = cnt_q[i] != '0;
    end
  end

  logic accept;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // search
  logic              found;
  logic [PIdxW-1:0]  win;
  logic [TW-1:0]     best;
  logic [PIdxW-1:0]  win_idx;
  assign win_idx = win;

  // memory write on push, read of the winner's head or the next slot
  logic                push_ok;
  logic                mem_we;
  logic [AddrW-1:0]    waddr, raddr;
  eta_arb_pkg::entry_t wentry, rentry;
  logic [SlotW-1:0]    next_rd;
  logic                head_we;
  logic [PIdxW-1:0]    head_port;
  logic [TW-1:0]       head_time;

  assign push_ok = accept && act == eta_arb_pkg::ACT_PUSH && port_ok &&
                   in_time >= ltime_q[pidx] && 32'(cnt_q[pidx]) < FIFO_DEPTH;
  assign mem_we  = push_ok;
  assign waddr   = {pidx, wr_ptr_q[pidx]};
  assign wentry  = '{etime: in_time, tag: in_tag, phase: in_phase};
  assign next_rd = (32'(rd_ptr_q[win_q]) + 1 >= FIFO_DEPTH) ? '0
                   : SlotW'(rd_ptr_q[win_q] + 1'b1);
  // after a pop, fetch the new head of the winner to refresh its head time
  assign raddr   = (state_q == S_READ) ? {win_q, next_rd} : {win_idx, rd_ptr_q[win_idx]};

  eta_arb_store #(.AddrW(AddrW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  // head time refresh: push to empty port, or new head after a pop
  always_comb begin
    head_we   = 1'b0;
    head_port = pidx;
    head_time = in_time;
    if (push_ok && cnt_q[pidx] == '0) begin
      head_we = 1'b1;
    end else if (state_q == S_OUT) begin
      head_we   = 1'b1;
      head_port = win_q;
      head_time = rentry.etime;
    end
  end

  eta_arb_heads #(.Ports(PORTS), .PortW(PIdxW)) u_heads (
    .clk_i        (clk_i),
    .head_we_i    (head_we),
    .head_port_i  (head_port),
    .head_time_i  (head_time),
    .active_i     (active_q),
    .nonempty_i   (nonempty),
    .local_time_i (ltime_q),
    .found_o      (found),
    .win_o        (win),
    .best_o       (best)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && act == eta_arb_pkg::ACT_POP && found && nonempty[win_idx]) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result word valid: set by a command that needs no memory read or by the pop read
  always_comb begin
    ovalid_d = ovalid_q && !m_axis_tready_i;
    if (accept && !(act == eta_arb_pkg::ACT_POP && found && nonempty[win_idx])) begin
      ovalid_d = 1'b1;
    end
    if (state_q == S_READ) begin
      ovalid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      ltime_q  <= '0;
      active_q <= '0;
      win_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (push_ok) begin
        wr_ptr_q[pidx] <= (32'(wr_ptr_q[pidx]) + 1 >= FIFO_DEPTH) ? '0
                          : SlotW'(wr_ptr_q[pidx] + 1'b1);
        cnt_q[pidx]    <= cnt_q[pidx] + 1'b1;
      end
      if (accept) begin
        unique case (act)
          eta_arb_pkg::ACT_SET_TIME: if (port_ok) ltime_q[pidx] <= in_time;
          eta_arb_pkg::ACT_SET_ACT:  if (port_ok) active_q[pidx] <= in_flag;
          default: ;
        endcase
        if (act == eta_arb_pkg::ACT_POP) begin
          win_q <= win_idx;
        end
      end
      if (state_q == S_READ) begin
        rd_ptr_q[win_q] <= next_rd;
        cnt_q[win_q]    <= cnt_q[win_q] - 1'b1;
      end
    end
  end

  // result payload
  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d = '0;
      unique case (act)
        eta_arb_pkg::ACT_PUSH: begin
          if (!port_ok) res_d.status = eta_arb_pkg::ST_FULL;
          else if (in_time < ltime_q[pidx]) res_d.status = eta_arb_pkg::ST_ORDER_ERR;
          else if (32'(cnt_q[pidx]) >= FIFO_DEPTH) res_d.status = eta_arb_pkg::ST_FULL;
          else res_d.status = eta_arb_pkg::ST_DONE;
        end
        eta_arb_pkg::ACT_POP: begin
          if (!found) begin
            res_d.status = eta_arb_pkg::ST_NO_ACTIVE;
          end else if (!nonempty[win_idx]) begin
            res_d.status = eta_arb_pkg::ST_IDLE_WIN;
            res_d.port   = 4'(win);
            res_d.otime  = best;
          end else begin
            res_d.port = 4'(win);
          end
        end
        default: ;
      endcase
    end else if (state_q == S_READ) begin
      res_d.tag   = rentry.tag;
      res_d.phase = rentry.phase;
      res_d.otime = rentry.etime;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'd0, res_q.otime, res_q.phase, res_q.tag, res_q.port,
                            res_q.status};

  `ETA_ASSERT(a_no_accept_busy, !(accept && state_q != S_IDLE), "accept while busy")
  `ETA_ASSERT_NEXT(a_read_then_out, state_q == S_READ, state_q == S_OUT && ovalid_q, "no out")
  `ETA_ASSERT(a_count_range, 32'(cnt_q[win_q]) <= FIFO_DEPTH, "fill count overflow")
  `ETA_ASSERT(a_pop_nonempty, !(state_q == S_READ && cnt_q[win_q] == '0), "pop from empty")

endmodule
